// ===== hw/rtl/ffra_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffra_pkg
// Shared types and codes of the first-fit region allocator.
// ----------------------------------------------------------------------------
package ffra_pkg;

   localparam int ADDR_W = 20;
   localparam int LEN_W  = 21;

   localparam logic [1:0] CMD_ALLOC    = 2'd0;
   localparam logic [1:0] CMD_FREE_ALL = 2'd1;
   localparam logic [1:0] CMD_COMPACT  = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_NO_SPACE  = 2'd2;
   localparam logic [1:0] ST_ZERO_SIZE = 2'd3;

   localparam logic [0:0] CSR_COMPACT_BASE  = 1'd0;
   localparam logic [0:0] CSR_COMPACT_LIMIT = 1'd1;

   localparam logic [ADDR_W-1:0] COMPACT_BASE_RESET  = 20'h00000;
   localparam logic [ADDR_W-1:0] COMPACT_LIMIT_RESET = 20'h9FFFF;

   typedef struct packed {
      logic [1:0]        command;
      logic [ADDR_W-1:0] window_low;
      logic [ADDR_W-1:0] window_high;
      logic [LEN_W-1:0]  request_size;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [ADDR_W-1:0] block_address;
      logic [7:0]        live_blocks;
      logic [LEN_W-1:0]  free_bytes;
   } rsp_type;

   typedef struct packed {
      logic [ADDR_W-1:0] start;
      logic [LEN_W-1:0]  length;
   } entry_type;

endpackage

// ===== hw/rtl/first_fit_region_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_region_allocator
// Free-all, unknown command and rejected allocate (table full or zero size)
// go straight to the result; other allocates and compact run a stable
// insertion sort of the table, then walk the entries in order; compact
// sorts again after packing.
// One command at a time; the table memory port sets the pace.
// Synchronous reset empties the table and loads the compaction registers.
// ----------------------------------------------------------------------------
module first_fit_region_allocator #(
   parameter int MAX_ENTRIES = 128,
   parameter int MEM_BYTES   = 1048576
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ffra_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ffra_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [0:0]        csr_index,
   input  logic [19:0]       csr_wdata
);

   localparam int IW = $clog2(MAX_ENTRIES);
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int UW = $clog2(MEM_BYTES + 1);
   localparam int SW = ((UW > 21) ? UW : 21) + 1;
   localparam int PW = 22;

   typedef enum logic [9:0] {
      S_IDLE     = 10'b0000000001,
      S_SORT_RD  = 10'b0000000010,
      S_SORT_KEY = 10'b0000000100,
      S_SORT_CMP = 10'b0000001000,
      S_WALK_RD  = 10'b0000010000,
      S_WALK_EV  = 10'b0000100000,
      S_PACK_RD  = 10'b0001000000,
      S_PACK_EV  = 10'b0010000000,
      S_DONE     = 10'b0100000000,
      S_START    = 10'b1000000000
   } state_type;

   state_type           state_ff, state_in;
   logic [19:0]         base_ff, base_in, limit_ff, limit_in;
   logic [CW-1:0]       count_ff, count_in, i_ff, i_in, j_ff, j_in;
   logic [UW-1:0]       used_ff, used_in;
   logic [1:0]          cmd_ff, cmd_in, status_ff, status_in;
   logic [19:0]         lo_ff, lo_in, hi_ff, hi_in, addr_ff, addr_in;
   logic [19:0]         cursor_ff, cursor_in;
   logic [20:0]         size_ff, size_in;
   logic [PW-1:0]       pos_ff, pos_in;
   logic                second_ff, second_in;
   ffra_pkg::entry_type key_ff, key_in;
   logic                rsp_valid_ff, rsp_valid_in;
   ffra_pkg::rsp_type   rsp_ff, rsp_in;

   logic                wr_en;
   logic [IW-1:0]       wr_addr, rd_addr;
   ffra_pkg::entry_type wr_data, rd_data;

   logic [PW-1:0]       end_excl, ent_start, limit_w, bend;
   logic                in_tbl, fit;
   logic [SW-1:0]       used_sum;
   logic [UW-1:0]       free_w;

   ffra_table #(.DEPTH(MAX_ENTRIES), .IW(IW)) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign end_excl  = PW'(hi_ff) + PW'(1);
   assign ent_start = PW'(rd_data.start);
   assign in_tbl    = i_ff < count_ff;
   assign limit_w   = (in_tbl && ent_start < end_excl) ? ent_start : end_excl;
   assign fit       = (limit_w >= pos_ff) && ((limit_w - pos_ff) >= PW'(size_ff));
   assign bend      = ent_start + PW'(rd_data.length);
   assign used_sum  = SW'(used_ff) + SW'(size_ff);
   assign free_w    = UW'(MEM_BYTES) - used_ff;

   always_comb begin
      state_in     = state_ff;
      base_in      = base_ff;
      limit_in     = limit_ff;
      count_in     = count_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      used_in      = used_ff;
      cmd_in       = cmd_ff;
      status_in    = status_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      addr_in      = addr_ff;
      cursor_in    = cursor_ff;
      size_in      = size_ff;
      pos_in       = pos_ff;
      second_in    = second_ff;
      key_in       = key_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = j_ff[IW-1:0];
      wr_data      = key_ff;
      rd_addr      = i_ff[IW-1:0];

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (csr_we) begin
         unique case (csr_index)
            ffra_pkg::CSR_COMPACT_BASE:  base_in  = csr_wdata;
            ffra_pkg::CSR_COMPACT_LIMIT: limit_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in    = req_data.command;
               lo_in     = req_data.window_low;
               hi_in     = req_data.window_high;
               size_in   = req_data.request_size;
               status_in = ffra_pkg::ST_OK;
               addr_in   = '0;
               second_in = 1'b0;
               state_in  = S_START;
            end
         end
         S_START: begin
            i_in = CW'(1);
            priority if (cmd_ff == ffra_pkg::CMD_ALLOC) begin
               if (count_ff >= CW'(MAX_ENTRIES)) begin
                  status_in = ffra_pkg::ST_FULL;
                  state_in  = S_DONE;
               end else if (size_ff == '0) begin
                  status_in = ffra_pkg::ST_ZERO_SIZE;
                  state_in  = S_DONE;
               end else begin
                  state_in = S_SORT_RD;
               end
            end else if (cmd_ff == ffra_pkg::CMD_FREE_ALL) begin
               count_in = '0;
               used_in  = '0;
               state_in = S_DONE;
            end else if (cmd_ff == ffra_pkg::CMD_COMPACT) begin
               state_in = S_SORT_RD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_SORT_RD: begin
            if (i_ff >= count_ff) begin
               i_in      = '0;
               pos_in    = PW'(lo_ff);
               cursor_in = base_ff;
               priority if (cmd_ff == ffra_pkg::CMD_ALLOC) begin
                  state_in = S_WALK_RD;
               end else if (!second_ff) begin
                  state_in = S_PACK_RD;
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               state_in = S_SORT_KEY;
            end
         end
         S_SORT_KEY: begin
            key_in   = rd_data;
            j_in     = i_ff;
            rd_addr  = IW'(i_ff - CW'(1));
            state_in = S_SORT_CMP;
         end
         S_SORT_CMP: begin
            wr_en = 1'b1;
            if (j_ff != '0 && rd_data.start > key_ff.start) begin
               wr_data = rd_data;
               j_in    = j_ff - CW'(1);
               rd_addr = IW'(j_ff - CW'(2));
            end else begin
               i_in     = i_ff + CW'(1);
               state_in = S_SORT_RD;
            end
         end
         S_WALK_RD: begin
            state_in = S_WALK_EV;
         end
         S_WALK_EV: begin
            if (fit) begin
               wr_en         = 1'b1;
               wr_addr       = count_ff[IW-1:0];
               wr_data.start = pos_ff[19:0];
               wr_data.length = size_ff;
               count_in      = count_ff + CW'(1);
               used_in       = (used_sum >= SW'(MEM_BYTES)) ? UW'(MEM_BYTES)
                                                            : UW'(used_sum);
               addr_in       = pos_ff[19:0];
               state_in      = S_DONE;
            end else if (in_tbl) begin
               if (bend > pos_ff) begin
                  pos_in = bend;
               end
               i_in     = i_ff + CW'(1);
               state_in = S_WALK_RD;
            end else begin
               status_in = ffra_pkg::ST_NO_SPACE;
               state_in  = S_DONE;
            end
         end
         S_PACK_RD: begin
            if (in_tbl) begin
               state_in = S_PACK_EV;
            end else begin
               second_in = 1'b1;
               i_in      = CW'(1);
               state_in  = S_SORT_RD;
            end
         end
         S_PACK_EV: begin
            wr_addr = i_ff[IW-1:0];
            wr_data = rd_data;
            if (rd_data.start < limit_ff) begin
               wr_en         = 1'b1;
               wr_data.start = cursor_ff;
               cursor_in     = cursor_ff + rd_data.length[19:0];
            end
            i_in     = i_ff + CW'(1);
            state_in = S_PACK_RD;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in         = 1'b1;
               rsp_in.status        = status_ff;
               rsp_in.block_address = addr_ff;
               rsp_in.live_blocks   = 8'(count_ff);
               rsp_in.free_bytes    = 21'(free_w);
               state_in             = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         base_ff      <= ffra_pkg::COMPACT_BASE_RESET;
         limit_ff     <= ffra_pkg::COMPACT_LIMIT_RESET;
         count_ff     <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         limit_ff     <= limit_in;
         count_ff     <= count_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      i_ff      <= i_in;
      j_ff      <= j_in;
      cmd_ff    <= cmd_in;
      status_ff <= status_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      addr_ff   <= addr_in;
      cursor_ff <= cursor_in;
      size_ff   <= size_in;
      pos_ff    <= pos_in;
      second_ff <= second_in;
      key_ff    <= key_in;
      rsp_ff    <= rsp_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ENTRIES))
      else $error("block count above table depth");

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= UW'(MEM_BYTES))
      else $error("used total above memory size");

   a_done_issues: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && (!rsp_valid_ff || rsp_ready)) |=> rsp_valid_ff)
      else $error("finished command produced no result beat");

   a_alloc_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK_EV && fit) |=> count_ff == $past(count_ff) + CW'(1))
      else $error("successful allocate did not add a block");

endmodule

// ===== hw/rtl/ffra_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffra_table
// Block table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ffra_table #(
   parameter int DEPTH = 128,
   parameter int IW    = 7
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [IW-1:0]       wr_addr,
   input  ffra_pkg::entry_type wr_data,
   input  logic [IW-1:0]       rd_addr,
   output ffra_pkg::entry_type rd_data
);

   ffra_pkg::entry_type mem [DEPTH];
   ffra_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
